// ----- src/lhp_pkg.sv -----
package lhp_pkg;

  // CORDIC datapath widths: x/y hold Lab axes times 256 plus gain growth,
  // z holds degrees times 65536 over the span [-100, 280] degrees
  localparam int X_W = 27;
  localparam int Z_W = 27;
  localparam int ATAN_W = 23;

  // atan(2^-i) in degrees times 65536, rounded
  localparam int ANGLE_TABLE_LEN = 24;
  localparam logic [ATAN_W-1:0] ATAN_TABLE [ANGLE_TABLE_LEN] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
    23'd234379,  23'd117304,  23'd58666,  23'd29335,
    23'd14668,   23'd7334,    23'd3667,   23'd1833,
    23'd917,     23'd458,     23'd229,    23'd115,
    23'd57,      23'd29,      23'd14,     23'd7,
    23'd4,       23'd2,       23'd1,      23'd0
  };

  localparam logic signed [Z_W-1:0] DEG180 = 27'sd11796480;
  localparam logic signed [Z_W-1:0] DEG360 = 27'sd23592960;

  // CORDIC gain compensation 0.60725293 in Q0.24
  localparam logic [23:0] GAIN_Q24 = 24'd10188014;
  localparam logic [18:0] CHROMA_MAX = 19'd46341;
  localparam logic [16:0] HUE_FULL = 17'd46080;

  localparam int PROD_W = X_W - 1 + 24;

endpackage

// ----- src/lab_to_hcl_polar_top.sv -----
// Lab to LCh converter, pipelined vectoring CORDIC, one CORDIC iteration per stage.
// Pipeline stages: one pre-rotation stage, CORDIC_STEPS iteration stages, gain multiply, output.
// Throughput: one item per clock; busy is always low and the receiver cannot stall.
// Reset (rst, synchronous, active high) clears all stage valid bits and done;
// payload registers are not reset.
module lab_to_hcl_polar_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [14:0] lightness_in,
  input  logic [15:0] green_red_axis,
  input  logic [15:0] blue_yellow_axis,
  output logic        done,
  output logic [15:0] hue_out,
  output logic [15:0] chroma_out,
  output logic [14:0] lightness_out
);

  localparam int XW = lhp_pkg::X_W;
  localparam int ZW = lhp_pkg::Z_W;
  localparam int PW = lhp_pkg::PROD_W;

  // per-stage pipeline registers, index 0 is the pre-rotated item
  logic                 vld   [0:CORDIC_STEPS];
  logic                 zero  [0:CORDIC_STEPS];
  logic signed [XW-1:0] xr    [0:CORDIC_STEPS];
  logic signed [XW-1:0] yr    [0:CORDIC_STEPS];
  logic signed [ZW-1:0] zr    [0:CORDIC_STEPS];
  logic [14:0]          light [0:CORDIC_STEPS];

  logic signed [XW-1:0] a_ext;
  logic signed [XW-1:0] b_ext;
  logic                 accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // axes scaled by 256 into the CORDIC format
  assign a_ext = {{(XW-24){green_red_axis[15]}}, green_red_axis, 8'd0};
  assign b_ext = {{(XW-24){blue_yellow_axis[15]}}, blue_yellow_axis, 8'd0};

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= accept;
    end
    zero[0]  <= (green_red_axis == 16'd0) && (blue_yellow_axis == 16'd0);
    light[0] <= lightness_in;
    if (green_red_axis[15]) begin
      xr[0] <= -a_ext;
      yr[0] <= -b_ext;
      zr[0] <= lhp_pkg::DEG180;
    end else begin
      xr[0] <= a_ext;
      yr[0] <= b_ext;
      zr[0] <= '0;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] ang;

    assign xs  = xr[i] >>> i;
    assign ys  = yr[i] >>> i;
    assign ang = signed'({{(ZW-lhp_pkg::ATAN_W){1'b0}}, lhp_pkg::ATAN_TABLE[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      zero[i+1]  <= zero[i];
      light[i+1] <= light[i];
      if (!yr[i][XW-1]) begin
        xr[i+1] <= xr[i] + ys;
        yr[i+1] <= yr[i] - xs;
        zr[i+1] <= zr[i] + ang;
      end else begin
        xr[i+1] <= xr[i] - ys;
        yr[i+1] <= yr[i] + xs;
        zr[i+1] <= zr[i] - ang;
      end
    end
  end

  // gain multiply and angle wrap
  logic                 m_vld;
  logic                 m_zero;
  logic [14:0]          m_light;
  logic [PW-1:0]        m_prod;
  logic [ZW-2:0]        m_ang;
  logic [XW-2:0]        x_mag;
  logic signed [ZW-1:0] z_fin;
  logic signed [ZW-1:0] z_pos;
  logic signed [ZW-1:0] z_wrap;

  assign x_mag = xr[CORDIC_STEPS][XW-1] ? '0 : xr[CORDIC_STEPS][XW-2:0];
  assign z_fin = zr[CORDIC_STEPS];

  always_comb begin
    z_pos = z_fin;
    if (z_fin < 0) begin
      z_pos = z_fin + lhp_pkg::DEG360;
    end
    z_wrap = z_pos;
    if (z_pos >= lhp_pkg::DEG360) begin
      z_wrap = z_pos - lhp_pkg::DEG360;
    end
    if (z_wrap < 0) begin
      z_wrap = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= vld[CORDIC_STEPS];
    end
    m_zero  <= zero[CORDIC_STEPS];
    m_light <= light[CORDIC_STEPS];
    m_prod  <= PW'(x_mag) * PW'(lhp_pkg::GAIN_Q24);
    m_ang   <= z_wrap[ZW-2:0];
  end

  // rounding, saturation and output register
  logic [PW:0]   prod_rnd;
  logic [18:0]   chroma_raw;
  logic [ZW-1:0] ang_rnd;
  logic [16:0]   hue_raw;

  assign prod_rnd   = {1'b0, m_prod} + (PW+1)'(64'd2147483648);
  assign chroma_raw = 19'(prod_rnd[PW:32]);
  assign ang_rnd    = {1'b0, m_ang} + ZW'(256);
  assign hue_raw    = 17'(ang_rnd[ZW-1:9]);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_vld;
    end
    lightness_out <= m_light;
    if (m_zero) begin
      chroma_out <= '0;
      hue_out    <= '0;
    end else begin
      chroma_out <= (chroma_raw > lhp_pkg::CHROMA_MAX) ? lhp_pkg::CHROMA_MAX[15:0]
                                                        : chroma_raw[15:0];
      hue_out    <= (hue_raw >= lhp_pkg::HUE_FULL) ? 16'd0 : hue_raw[15:0];
    end
  end

endmodule

// ----- bench/tb_top.sv -----
package lch_check_pkg;

  // Expected hue/chroma/lightness of one pixel, with the source values it came from
  typedef struct packed {
    logic [14:0] lightness_src;
    logic [15:0] a_src;
    logic [15:0] b_src;
    logic [15:0] hue;
    logic [15:0] chroma;
    logic [14:0] lightness;
  } lch_t;

  // atan(2^-i) in degrees * 65536
  localparam int ARCTAN_LEN = 24;
  localparam longint ARCTAN_Q16 [ARCTAN_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };
  localparam longint HALF_TURN_Q16 = 64'sd180 * 65536;
  localparam longint FULL_TURN_Q16 = 64'sd360 * 65536;
  localparam longint unsigned K_INV_Q24 = 64'd10188014;
  localparam longint unsigned CHROMA_SAT = 64'd46341;
  localparam longint unsigned HUE_WRAP = 64'd46080;
  localparam int MAX_PRINTED = 40;

  class lch_scoreboard;
    lch_t pending_lch[$];
    int   errors;
    int   steps;

    function new(int steps);
      this.steps = steps;
      errors = 0;
    endfunction

    // Vectoring CORDIC on (a,b): magnitude and angle, degrees*128
    function lch_t compute_lch(logic [14:0] l, logic signed [15:0] a,
                               logic signed [15:0] b);
      longint x, y, z, xs, ys;
      longint unsigned prod, hue, chroma;
      lch_t r;
      r.lightness_src = l;
      r.a_src = a;
      r.b_src = b;
      r.lightness = l;
      hue = 0;
      chroma = 0;
      if (a != 0 || b != 0) begin
        // fold left half-plane onto the right
        if (a < 0) begin
          x = -longint'(a) * 256;
          y = -longint'(b) * 256;
          z = HALF_TURN_Q16;
        end else begin
          x = longint'(a) * 256;
          y = longint'(b) * 256;
          z = 0;
        end
        for (int i = 0; i < steps && i < ARCTAN_LEN; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ARCTAN_Q16[i];
          end else begin
            x = x - ys;
            y = y + xs;
            z = z - ARCTAN_Q16[i];
          end
        end
        if (x < 0) x = 0;
        // gain compensation, rounded to Q8.8
        prod = longint'(x) * K_INV_Q24 + 64'h8000_0000;
        chroma = prod >> 32;
        if (chroma > CHROMA_SAT) chroma = CHROMA_SAT;
        // wrap into [0,360) and round to 1/128 degree
        if (z < 0) z = z + FULL_TURN_Q16;
        if (z >= FULL_TURN_Q16) z = z - FULL_TURN_Q16;
        if (z < 0) z = 0;
        hue = (longint'(z) + 256) >> 9;
        if (hue >= HUE_WRAP) hue = 0;
      end
      r.hue = hue[15:0];
      r.chroma = chroma[15:0];
      return r;
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("%0t lch mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void note_pixel(logic [14:0] l, logic [15:0] a, logic [15:0] b);
      pending_lch.push_back(compute_lch(l, a, b));
    endfunction

    task check_pixel(logic [15:0] hue, logic [15:0] chroma, logic [14:0] l);
      lch_t e;
      if (pending_lch.size() == 0) begin
        report($sformatf("unexpected result hue=%0d chroma=%0d L=%0d", hue, chroma, l));
      end else begin
        e = pending_lch.pop_front();
        if (hue !== e.hue)
          report($sformatf("a=%0d b=%0d hue %0d, want %0d",
                           $signed(e.a_src), $signed(e.b_src), hue, e.hue));
        if (chroma !== e.chroma)
          report($sformatf("a=%0d b=%0d chroma %0d, want %0d",
                           $signed(e.a_src), $signed(e.b_src), chroma, e.chroma));
        if (l !== e.lightness)
          report($sformatf("L=%0d lightness %0d, want %0d",
                           e.lightness_src, l, e.lightness));
      end
    endtask

    function int outstanding();
      return pending_lch.size();
    endfunction
  endclass

endpackage

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 16;
  localparam int LATENCY = STEPS + 2;
  localparam int RANDOM_ITEMS = 1500;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [14:0] lightness_in = '0;
  logic [15:0] green_red_axis = '0;
  logic [15:0] blue_yellow_axis = '0;
  logic        done;
  logic [15:0] hue_out;
  logic [15:0] chroma_out;
  logic [14:0] lightness_out;

  lch_check_pkg::lch_scoreboard sb;

  lab_to_hcl_polar_top #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .lightness_in     (lightness_in),
    .green_red_axis   (green_red_axis),
    .blue_yellow_axis (blue_yellow_axis),
    .done             (done),
    .hue_out          (hue_out),
    .chroma_out       (chroma_out),
    .lightness_out    (lightness_out)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // results are strobed and cannot be held off; check every one
  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_pixel(hue_out, chroma_out, lightness_out);
  end

  // present one pixel and hold it until taken
  task automatic send_pixel(logic [14:0] l, logic [15:0] a, logic [15:0] b);
    @(negedge clk);
    start = 1'b1;
    lightness_in = l;
    green_red_axis = a;
    blue_yellow_axis = b;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_pixel(l, a, b);
  endtask

  // drop start, with junk on the data lines; n sets the length of the gap
  task automatic idle_cycles(int n);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      lightness_in = 15'($urandom);
      green_red_axis = 16'($urandom);
      blue_yellow_axis = 16'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // hold off until every pending result is back
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] edge_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h8001;
      2: return 16'hFFFF;
      3: return 16'h0000;
      4: return 16'h0001;
      default: return 16'h7FFF;
    endcase
  endfunction

  function automatic logic [15:0] near_zero();
    return 16'($urandom_range(0, 64)) - 16'd32;
  endfunction

  // mix of full-range, small, near-axis and extreme vectors
  task automatic random_pixel(output logic [14:0] l, output logic [15:0] a,
                              output logic [15:0] b);
    case ($urandom_range(0, 6))
      0: begin a = near_zero(); b = near_zero(); end
      1: begin a = 16'($urandom); b = near_zero(); end
      2: begin a = near_zero(); b = 16'($urandom); end
      3: begin a = edge_value(); b = edge_value(); end
      4: begin a = edge_value(); b = 16'($urandom); end
      default: begin a = 16'($urandom); b = 16'($urandom); end
    endcase
    if ($urandom_range(0, 9) < 8) l = 15'($urandom_range(0, 25600));
    else l = 15'($urandom);
  endtask

  // directed pixels: axes, quadrants, extremes, wrap and saturation cases
  localparam int N_DIRECTED = 22;
  localparam logic [15:0] DIR_A [N_DIRECTED] = '{
    16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h8000,
    16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001, 16'h0000, 16'hFFFF,
    16'h0000, 16'h0001, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h8000,
    16'h4000, 16'hC000, 16'h0100, 16'h0000
  };
  localparam logic [15:0] DIR_B [N_DIRECTED] = '{
    16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h8000,
    16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'h0000,
    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001,
    16'h4000, 16'hC000, 16'hFF00, 16'h0000
  };
  localparam logic [14:0] DIR_L [N_DIRECTED] = '{
    15'd0, 15'd25600, 15'd32767, 15'd12800, 15'd1, 15'd25600,
    15'd0, 15'd25601, 15'd16384, 15'd100, 15'd200, 15'd300,
    15'd400, 15'd500, 15'd25600, 15'd7, 15'd32767, 15'd0,
    15'd21845, 15'd10922, 15'd256, 15'd32767
  };

  initial begin
    logic [14:0] l;
    logic [15:0] a, b;
    int sent, burst, gap;

    sb = new(STEPS);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part, a few gaps mixed in
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_pixel(DIR_L[i], DIR_A[i], DIR_B[i]);
      if (i % 5 == 4) idle_cycles($urandom_range(1, 3));
    end
    drain();

    // random bursts; some bursts run with no gaps at all
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        random_pixel(l, a, b);
        send_pixel(l, a, b);
        sent++;
        if (sent == RANDOM_ITEMS / 2) drain();
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, LATENCY + 4);
      idle_cycles(gap);
    end

    drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule
